/* hw/rtl/ssa_pkg.sv */
package ssa_pkg;

  localparam int SLOTS_DEFAULT = 256;

  typedef enum logic [2:0] {
    OP_ALLOC     = 3'd0,
    OP_RELEASE   = 3'd1,
    OP_ACQUIRE   = 3'd2,
    OP_DROP      = 3'd3,
    OP_LOOKUP    = 3'd4,
    OP_SCAN      = 3'd5,
    OP_SET_OWNER = 3'd6,
    OP_GET_OWNER = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTUSED  = 3'd3,
    ST_OWNER    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EVAL
  } back_state_t;

  localparam logic [0:0] REG_BASE_ID    = 1'b0;
  localparam logic [0:0] REG_SLOT_COUNT = 1'b1;

  // classified word handed from front to back
  typedef struct packed {
    op_t         op;
    logic        in_range;
    logic [15:0] off;
    logic [15:0] node_id;
    logic [15:0] requester;
    logic [31:0] payload;
    logic [15:0] base;
    logic [15:0] limit;
  } item_t;

  typedef struct packed {
    logic [15:0] refs;
    logic [15:0] owner;
    logic [31:0] payload;
  } slot_t;

endpackage

/* hw/rtl/ssa_front.sv */
module ssa_front #(
  parameter int SLOTS = ssa_pkg::SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_op,
  input  logic [15:0]         in_node_id,
  input  logic [15:0]         in_requester,
  input  logic [31:0]         in_payload,
  input  logic [15:0]         base_id,
  input  logic [8:0]          slot_count,
  input  logic                fifo_full,
  input  logic                clearing,
  output logic                push,
  output ssa_pkg::item_t      push_item
);

  logic            valid_r, valid_nxt;
  ssa_pkg::item_t  item_r, item_nxt;
  logic            accept;
  logic [15:0]     limit;
  logic [15:0]     off;

  always_comb begin
    limit = ({7'd0, slot_count} > 16'(SLOTS)) ? 16'(SLOTS) : {7'd0, slot_count};
    off   = in_node_id - base_id;
    busy  = (valid_r & fifo_full) | clearing;
    push  = valid_r & ~fifo_full;
    accept = start & ~busy;
    valid_nxt = accept | (valid_r & fifo_full);
    item_nxt = item_r;
    if (accept) begin
      item_nxt.op        = ssa_pkg::op_t'(in_op);
      item_nxt.in_range  = (in_node_id >= base_id) && (off < limit);
      item_nxt.off       = off;
      item_nxt.node_id   = in_node_id;
      item_nxt.requester = in_requester;
      item_nxt.payload   = in_payload;
      item_nxt.base      = base_id;
      item_nxt.limit     = limit;
    end
  end

  assign push_item = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

/* hw/rtl/ssa_fifo.sv */
module ssa_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ssa_pkg::item_t  push_item,
  input  logic            pop,
  output ssa_pkg::item_t  head,
  output logic            empty,
  output logic            full
);

  ssa_pkg::item_t  buf_r [2];
  logic            wr_r, rd_r;
  logic [1:0]      cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = buf_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      buf_r[wr_r] <= push_item;
    end
  end

endmodule

/* hw/rtl/ssa_back.sv */
module ssa_back #(
  parameter int SLOTS = ssa_pkg::SLOTS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ssa_pkg::item_t  head,
  input  logic            empty,
  output logic            pop,
  output logic            clearing,
  output logic            out_valid,
  output logic [2:0]      out_status,
  output logic [15:0]     out_result_id,
  output logic [31:0]     out_result_payload,
  output logic [15:0]     out_result_owner,
  output logic [8:0]      out_active_slots
);

  localparam int IW = $clog2(SLOTS);

  ssa_pkg::slot_t  mem [SLOTS];
  ssa_pkg::slot_t  rdata_r;
  ssa_pkg::slot_t  wdata;
  logic [IW-1:0]   raddr, waddr;
  logic            we;

  ssa_pkg::back_state_t state_r, state_nxt;
  ssa_pkg::item_t  cur_r, cur_nxt;
  logic [IW-1:0]   ptr_r, ptr_nxt;
  logic [IW-1:0]   clr_r, clr_nxt;
  logic [8:0]      active_r, active_nxt;
  logic            ov_r, ov_nxt;
  logic [2:0]      st_r, st_nxt;
  logic [15:0]     rid_r, rid_nxt;
  logic [31:0]     rpay_r, rpay_nxt;
  logic [15:0]     rown_r, rown_nxt;
  logic            last;

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    ptr_nxt    = ptr_r;
    clr_nxt    = clr_r;
    active_nxt = active_r;
    ov_nxt     = 1'b0;
    st_nxt     = st_r;
    rid_nxt    = rid_r;
    rpay_nxt   = rpay_r;
    rown_nxt   = rown_r;
    pop        = 1'b0;
    we         = 1'b0;
    waddr      = ptr_r;
    wdata      = rdata_r;
    raddr      = ptr_r;
    last       = (16'(ptr_r) + 16'd1) >= cur_r.limit;
    unique case (state_r)
      ssa_pkg::BK_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IW'(SLOTS - 1)) begin
          state_nxt = ssa_pkg::BK_IDLE;
        end
      end
      ssa_pkg::BK_IDLE: begin
        if (!empty) begin
          pop     = 1'b1;
          cur_nxt = head;
          if (head.op != ssa_pkg::OP_ALLOC && !head.in_range) begin
            ov_nxt = 1'b1;
            st_nxt = ssa_pkg::ST_RANGE;
            rid_nxt = '0;
            rpay_nxt = '0;
            rown_nxt = '0;
          end else if (head.op == ssa_pkg::OP_ALLOC && head.limit == 16'd0) begin
            ov_nxt = 1'b1;
            st_nxt = ssa_pkg::ST_FULL;
            rid_nxt = '0;
            rpay_nxt = '0;
            rown_nxt = '0;
          end else begin
            raddr = (head.op == ssa_pkg::OP_ALLOC) ? '0 : head.off[IW-1:0];
            ptr_nxt = raddr;
            state_nxt = ssa_pkg::BK_EVAL;
          end
        end
      end
      ssa_pkg::BK_EVAL: begin
        ov_nxt   = 1'b1;
        st_nxt   = ssa_pkg::ST_OK;
        rid_nxt  = '0;
        rpay_nxt = '0;
        rown_nxt = '0;
        state_nxt = ssa_pkg::BK_IDLE;
        unique case (cur_r.op)
          ssa_pkg::OP_ALLOC: begin
            if (rdata_r.refs == 16'd0) begin
              we = 1'b1;
              wdata.refs    = 16'd1;
              wdata.owner   = cur_r.requester;
              wdata.payload = cur_r.payload;
              if (active_r != 9'd511) begin
                active_nxt = active_r + 9'd1;
              end
              rid_nxt = cur_r.base + 16'(ptr_r);
            end else if (last) begin
              st_nxt = ssa_pkg::ST_FULL;
            end else begin
              ov_nxt = 1'b0;
              state_nxt = ssa_pkg::BK_EVAL;
              ptr_nxt = ptr_r + 1'b1;
              raddr = ptr_nxt;
            end
          end
          ssa_pkg::OP_RELEASE: begin
            we = 1'b1;
            wdata = '0;
            if (active_r != 9'd0) begin
              active_nxt = active_r - 9'd1;
            end
          end
          ssa_pkg::OP_ACQUIRE: begin
            if (rdata_r.refs == 16'd0) begin
              st_nxt = ssa_pkg::ST_NOTUSED;
            end else if (rdata_r.refs != 16'hFFFF) begin
              we = 1'b1;
              wdata.refs = rdata_r.refs + 16'd1;
            end
          end
          ssa_pkg::OP_DROP: begin
            if (rdata_r.refs != 16'd0) begin
              we = 1'b1;
              wdata.refs = rdata_r.refs - 16'd1;
            end
          end
          ssa_pkg::OP_LOOKUP: begin
            if (rdata_r.refs == 16'd0) begin
              st_nxt = ssa_pkg::ST_NOTUSED;
            end else if (rdata_r.owner != cur_r.requester) begin
              st_nxt = ssa_pkg::ST_OWNER;
            end else begin
              rid_nxt  = cur_r.node_id;
              rpay_nxt = rdata_r.payload;
            end
          end
          ssa_pkg::OP_SCAN: begin
            if (rdata_r.refs != 16'd0 && rdata_r.owner == cur_r.requester) begin
              rid_nxt  = cur_r.base + 16'(ptr_r);
              rpay_nxt = rdata_r.payload;
            end else if (last) begin
              st_nxt = ssa_pkg::ST_NOTUSED;
            end else begin
              ov_nxt = 1'b0;
              state_nxt = ssa_pkg::BK_EVAL;
              ptr_nxt = ptr_r + 1'b1;
              raddr = ptr_nxt;
            end
          end
          ssa_pkg::OP_SET_OWNER: begin
            we = 1'b1;
            wdata.owner = cur_r.requester;
          end
          ssa_pkg::OP_GET_OWNER: begin
            rown_nxt = rdata_r.owner;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = ssa_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ssa_pkg::BK_CLEAR;
      clr_r    <= '0;
      active_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      active_r <= active_nxt;
      ov_r     <= ov_nxt;
    end
    cur_r  <= cur_nxt;
    ptr_r  <= ptr_nxt;
    st_r   <= st_nxt;
    rid_r  <= rid_nxt;
    rpay_r <= rpay_nxt;
    rown_r <= rown_nxt;
  end

  assign clearing           = (state_r == ssa_pkg::BK_CLEAR);
  assign out_valid          = ov_r;
  assign out_status         = st_r;
  assign out_result_id      = rid_r;
  assign out_result_payload = rpay_r;
  assign out_result_owner   = rown_r;
  assign out_active_slots   = active_r;

endmodule

/* hw/rtl/session_slot_allocator_core.sv */
// Session slot allocator: reference-counted table of SLOTS slots, each with
// a count, an owner id and a 32-bit payload handle.
// Command channel: an operation word is taken at a clock edge where start is
// high and busy is low. Each operation gives exactly one result word, shown
// on the out_ ports for one cycle with out_valid high; the receiver cannot
// stall it and must take it in that cycle.
// Config: APB-style port, base_id at address 0, slot_count at address 4;
// write only while no operation is in flight.
// Flow: the front classifies a word, a two-entry queue holds it and the back
// runs it against a slot memory with one write port and a registered read
// port. Range errors and allocate with no usable slots give out_valid from
// the back's idle state, operations on one slot after the registered read,
// and allocate and scan walk the slots one per cycle. The back takes no new
// word until the last one has given its result; busy rises only when the
// queue and the front register are both full, or during the memory clear.
// Reset: the back clears the slot memory, one slot per cycle, with busy
// high; config resets to base_id 0 and slot_count 256.
module session_slot_allocator_core #(
  parameter int SLOTS = ssa_pkg::SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [15:0] in_node_id,
  input  logic [15:0] in_requester,
  input  logic [31:0] in_payload,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_result_id,
  output logic [31:0] out_result_payload,
  output logic [15:0] out_result_owner,
  output logic [8:0]  out_active_slots,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]     cfg_base_id_r;
  logic [8:0]      cfg_slot_count_r;
  logic            push, pop, empty, full, clearing;
  ssa_pkg::item_t  push_item, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_base_id_r    <= 16'd0;
      cfg_slot_count_r <= 9'd256;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2:2])
        ssa_pkg::REG_BASE_ID:    cfg_base_id_r    <= pwdata[15:0];
        ssa_pkg::REG_SLOT_COUNT: cfg_slot_count_r <= pwdata[8:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2:2])
      ssa_pkg::REG_BASE_ID:    prdata = {16'd0, cfg_base_id_r};
      ssa_pkg::REG_SLOT_COUNT: prdata = {23'd0, cfg_slot_count_r};
      default:                 prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  ssa_front #(.SLOTS(SLOTS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_node_id   (in_node_id),
    .in_requester (in_requester),
    .in_payload   (in_payload),
    .base_id      (cfg_base_id_r),
    .slot_count   (cfg_slot_count_r),
    .fifo_full    (full),
    .clearing     (clearing),
    .push         (push),
    .push_item    (push_item)
  );

  ssa_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  ssa_back #(.SLOTS(SLOTS)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .empty              (empty),
    .pop                (pop),
    .clearing           (clearing),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_result_id      (out_result_id),
    .out_result_payload (out_result_payload),
    .out_result_owner   (out_result_owner),
    .out_active_slots   (out_active_slots)
  );

endmodule
